/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the ant stepper.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgas assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgas assertion failed");

`endif

/* rtl/tgas_pkg.sv */
// Package for the triangular grid ant stepper: grid geometry, reset values,
// controller states and the controller-to-datapath command struct. No dependencies.
package tgas_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 32;
  localparam int NUM_CELLS   = GRID_WIDTH * GRID_HEIGHT;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(NUM_CELLS);
  localparam int CLR_W  = 2;
  localparam int HEAD_W = 2;

  // Bias that keeps the heading sum positive before the modulo 3.
  localparam int TURN_BIAS = 6;

  localparam logic [COL_W-1:0] POS_COL_RST = COL_W'((GRID_WIDTH / 2) % GRID_WIDTH);
  localparam logic [ROW_W-1:0] POS_ROW_RST = ROW_W'((GRID_HEIGHT / 2 + 1) % GRID_HEIGHT);
  localparam logic [HEAD_W-1:0] HEADING_RST = 2'd1;
  localparam logic ORIENT_RST = POS_COL_RST[0] ^ POS_ROW_RST[0];

  localparam logic [CLR_W-1:0] RULE0_RST = 2'd0;
  localparam logic [CLR_W-1:0] RULE1_RST = 2'd1;
  localparam logic [CLR_W-1:0] RULE2_RST = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RULE0 = 2'd0;
  localparam logic [1:0] CFG_RULE1 = 2'd1;
  localparam logic [1:0] CFG_RULE2 = 2'd2;

  // Request commands.
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } tgas_state_t;

  typedef struct packed {
    logic              clear_we;
    logic [ADDR_W-1:0] clear_addr;
    logic              load;
    logic              exec;
  } tgas_cmd_t;

endpackage

/* rtl/triangular_grid_ant_step_top.sv */
// Top level of the triangular grid Langton's ant stepper.
// Depends on tgas_pkg, tgas_ctrl and tgas_dp.
//
// Usage:
// - Request channel: a request is taken at a rising edge where start is high and busy
//   is low. in_cmd selects a step of the ant or a read of the cell at
//   in_read_col / in_read_row.
// - Result channel: out_valid is high for exactly one cycle, registered from the
//   execute state that follows the request. It carries the ant position, heading and
//   orientation after the request, the cell colour and the ant-on-cell flag. The
//   receiver cannot stall.
// - Sequence: the grid memory is read at the accepting edge. The next cycle computes,
//   for a step, the new ant state and writes the cell back at its end. The cycle after
//   that shows the result. busy drops in the cycle the result is shown, so a new
//   request can be taken at the edge that ends it.
// - Configuration: cfg_we writes the turn rule at cfg_addr (0 to 2) with cfg_wdata;
//   index 3 is ignored. Write only while no request is in flight.
// - Reset: rst_n is synchronous and active low. After reset the controller sweeps the
//   2048-cell grid to colour 0, one cell per cycle, holding busy high until the sweep ends;
//   configuration writes are taken during the sweep.
module triangular_grid_ant_step_top
  import tgas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [COL_W-1:0]  in_read_col,
  input  logic [ROW_W-1:0]  in_read_row,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CLR_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [COL_W-1:0]  out_ant_col,
  output logic [ROW_W-1:0]  out_ant_row,
  output logic [HEAD_W-1:0] out_ant_heading,
  output logic              out_ant_orient,
  output logic [CLR_W-1:0]  out_cell_colour,
  output logic              out_ant_on_cell
);

  // Command bundle from the controller to the datapath.
  tgas_cmd_t cmd;

  // The controller owns sequencing: clearing sweep, request load, execute and strobe.
  tgas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds the grid memory, the ant state and the turn rules.
  tgas_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_cmd          (in_cmd),
    .in_read_col     (in_read_col),
    .in_read_row     (in_read_row),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .out_ant_col     (out_ant_col),
    .out_ant_row     (out_ant_row),
    .out_ant_heading (out_ant_heading),
    .out_ant_orient  (out_ant_orient),
    .out_cell_colour (out_cell_colour),
    .out_ant_on_cell (out_ant_on_cell)
  );

endmodule

/* rtl/tgas_ctrl.sv */
// Controller of the ant stepper: grid clearing sweep, request sequencing, result strobe.
// Depends on tgas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tgas_ctrl
  import tgas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output tgas_cmd_t cmd
);

  tgas_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              clr_last;

  assign clr_last = (clr_cnt_r == ADDR_W'(NUM_CELLS - 1));
  assign accept   = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    busy          = 1'b1;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_we   = 1'b1;
        cmd.clear_addr = clr_cnt_r;
        clr_cnt_nxt    = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TGAS_ASSERT_NXT(a_accept_exec, clk, rst_n, accept, state_r == ST_EXEC)
  `TGAS_ASSERT_NXT(a_exec_strobe, clk, rst_n, state_r == ST_EXEC, out_valid_r && !busy)
  `TGAS_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r)
  `TGAS_ASSERT_NXT(a_clear_done, clk, rst_n, (state_r == ST_CLEAR) && clr_last,
                   state_r == ST_IDLE)

endmodule

/* rtl/tgas_dp.sv */
// Datapath of the ant stepper: colour grid memory, ant state, turn rule registers
// and the heading/move arithmetic. Depends on tgas_pkg.
module tgas_dp
  import tgas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tgas_cmd_t         cmd,
  input  logic              in_cmd,
  input  logic [COL_W-1:0]  in_read_col,
  input  logic [ROW_W-1:0]  in_read_row,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CLR_W-1:0]  cfg_wdata,
  output logic [COL_W-1:0]  out_ant_col,
  output logic [ROW_W-1:0]  out_ant_row,
  output logic [HEAD_W-1:0] out_ant_heading,
  output logic              out_ant_orient,
  output logic [CLR_W-1:0]  out_cell_colour,
  output logic              out_ant_on_cell
);

  logic [CLR_W-1:0]  grid_mem [NUM_CELLS];
  logic [CLR_W-1:0]  rdata_r;

  logic [CLR_W-1:0]  rule0_r, rule1_r, rule2_r;
  logic [COL_W-1:0]  pos_col_r, pos_col_nxt;
  logic [ROW_W-1:0]  pos_row_r, pos_row_nxt;
  logic [HEAD_W-1:0] heading_r, heading_nxt;
  logic              orient_neg_r;
  logic              op_r;
  logic [COL_W-1:0]  rd_col_r;
  logic [ROW_W-1:0]  rd_row_r;
  logic [CLR_W-1:0]  colour_r, colour_nxt;
  logic              on_cell_r;

  logic [ADDR_W-1:0] rd_addr, ant_addr, wr_addr;
  logic [CLR_W-1:0]  wr_data;
  logic              wr_en;
  logic              is_step;
  logic [CLR_W-1:0]  rule_sel;
  logic [HEAD_W-1:0] head_inc;
  logic [3:0]        turn_base, turn_sum;
  logic              even_par;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [COL_W-1:0] col,
                                                  logic [ROW_W-1:0] row);
    return ADDR_W'(col) * ADDR_W'(GRID_HEIGHT) + ADDR_W'(row);
  endfunction

  // Reduces a value below 16 modulo 3 by three conditional subtractions.
  function automatic logic [HEAD_W-1:0] mod3(logic [3:0] v);
    logic [3:0] a;
    a = v;
    if (a >= 4'd12) a = a - 4'd12;
    if (a >= 4'd6)  a = a - 4'd6;
    if (a >= 4'd3)  a = a - 4'd3;
    return a[HEAD_W-1:0];
  endfunction

  // Read coordinates span exactly the grid, so they need no wrap here.
  assign ant_addr = cell_addr(pos_col_r, pos_row_r);
  assign rd_addr  = (in_cmd == CMD_READ) ? cell_addr(in_read_col, in_read_row) : ant_addr;

  assign is_step = cmd.exec && (op_r == CMD_STEP);
  assign wr_en   = cmd.clear_we || is_step;
  assign wr_addr = cmd.clear_we ? cmd.clear_addr : ant_addr;
  assign wr_data = cmd.clear_we ? '0 : colour_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    if (cmd.load) rdata_r <= grid_mem[rd_addr];
  end

  always_comb begin
    unique case (rdata_r)
      2'd0:    rule_sel = rule0_r;
      2'd1:    rule_sel = rule1_r;
      default: rule_sel = rule2_r;
    endcase
  end

  assign even_par  = ~(pos_col_r[0] ^ pos_row_r[0]);
  assign head_inc  = (heading_r == 2'd2) ? 2'd0 : heading_r + 2'd1;
  assign turn_base = 4'(heading_r) + 4'(rule_sel);

  always_comb begin
    turn_sum = orient_neg_r ? (4'(TURN_BIAS) - turn_base) : (4'(TURN_BIAS) + turn_base);
    if (even_par) turn_sum = turn_sum + 4'(head_inc);
    heading_nxt = mod3(turn_sum);
    colour_nxt  = (rdata_r == 2'd2) ? 2'd0 : rdata_r + 2'd1;
  end

  always_comb begin
    unique case (heading_nxt)
      2'd0:    pos_col_nxt = (pos_col_r == COL_W'(GRID_WIDTH - 1)) ? '0 : pos_col_r + 1'b1;
      2'd1:    pos_col_nxt = pos_col_r;
      default: pos_col_nxt = (pos_col_r == '0) ? COL_W'(GRID_WIDTH - 1) : pos_col_r - 1'b1;
    endcase
    pos_row_nxt = pos_row_r;
    if (heading_nxt == 2'd1) begin
      if (orient_neg_r) begin
        pos_row_nxt = (pos_row_r == '0) ? ROW_W'(GRID_HEIGHT - 1) : pos_row_r - 1'b1;
      end else begin
        pos_row_nxt = (pos_row_r == ROW_W'(GRID_HEIGHT - 1)) ? '0 : pos_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule0_r      <= RULE0_RST;
      rule1_r      <= RULE1_RST;
      rule2_r      <= RULE2_RST;
      pos_col_r    <= POS_COL_RST;
      pos_row_r    <= POS_ROW_RST;
      heading_r    <= HEADING_RST;
      orient_neg_r <= ORIENT_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_RULE0: rule0_r <= cfg_wdata;
          CFG_RULE1: rule1_r <= cfg_wdata;
          CFG_RULE2: rule2_r <= cfg_wdata;
          default:   ;
        endcase
      end
      if (is_step) begin
        pos_col_r    <= pos_col_nxt;
        pos_row_r    <= pos_row_nxt;
        heading_r    <= heading_nxt;
        orient_neg_r <= ~orient_neg_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_cmd;
      rd_col_r <= in_read_col;
      rd_row_r <= in_read_row;
    end
    if (cmd.exec) begin
      colour_r  <= (op_r == CMD_STEP) ? colour_nxt : rdata_r;
      on_cell_r <= (op_r == CMD_READ) && (rd_col_r == pos_col_r) && (rd_row_r == pos_row_r);
    end
  end

  assign out_ant_col     = pos_col_r;
  assign out_ant_row     = pos_row_r;
  assign out_ant_heading = heading_r;
  assign out_ant_orient  = orient_neg_r;
  assign out_cell_colour = colour_r;
  assign out_ant_on_cell = on_cell_r;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the triangular grid Langton's ant stepper.
// Depends on tgas_pkg and triangular_grid_ant_step_top; needs no other files.
module testbench
  import tgas_pkg::*;
;

  // There is no package name for the unused register slot. Writes there must be ignored.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // One result as the block reports it: the ant after the request, plus the cell data.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [HEAD_W-1:0] heading;
    logic              orient;
    logic [CLR_W-1:0]  colour;
    logic              on_cell;
  } ant_report_t;

  // The scoreboard keeps its own copy of the grid, the ant and the turn rules.
  // Every accepted request is run against that copy at once, and the predicted report
  // is queued until the block shows its result.
  class ant_walk_scoreboard;
    logic [CLR_W-1:0]  grid [NUM_CELLS];
    logic [COL_W-1:0]  ant_col;
    logic [ROW_W-1:0]  ant_row;
    logic [HEAD_W-1:0] ant_heading;
    logic              ant_orient;
    logic [CLR_W-1:0]  turn_rule [3];
    ant_report_t       expected_reports [$];
    int                errors;

    function new();
      for (int i = 0; i < NUM_CELLS; i++) grid[i] = '0;
      ant_col      = POS_COL_RST;
      ant_row      = POS_ROW_RST;
      ant_heading  = HEADING_RST;
      ant_orient   = ORIENT_RST;
      turn_rule[0] = RULE0_RST;
      turn_rule[1] = RULE1_RST;
      turn_rule[2] = RULE2_RST;
      errors       = 0;
    endfunction

    function void set_rule(logic [1:0] idx, logic [CLR_W-1:0] val);
      if (idx <= CFG_RULE2) turn_rule[idx] = val;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_request(logic cmd, logic [COL_W-1:0] rc, logic [ROW_W-1:0] rr);
      ant_report_t rep;
      int idx, old_c, even, base, turn, col_n, row_n;
      rep.on_cell = 1'b0;
      if (cmd == CMD_READ) begin
        rep.colour  = grid[int'(rc) * GRID_HEIGHT + int'(rr)];
        rep.on_cell = (rc == ant_col && rr == ant_row);
      end else begin
        idx   = int'(ant_col) * GRID_HEIGHT + int'(ant_row);
        old_c = int'(grid[idx]) % 3;
        even  = (ant_col[0] ^ ant_row[0]) ? 0 : 1;
        base  = int'(ant_heading) + int'(turn_rule[old_c]);
        turn  = ant_orient ? (TURN_BIAS - base) : (TURN_BIAS + base);
        turn  = turn + even * ((int'(ant_heading) + 1) % 3);
        ant_heading = HEAD_W'(turn % 3);
        rep.colour  = CLR_W'((old_c + 1) % 3);
        grid[idx]   = rep.colour;
        col_n = (1 + int'(ant_col) + GRID_WIDTH - int'(ant_heading)) % GRID_WIDTH;
        row_n = int'(ant_row);
        if (ant_heading == 2'd1) begin
          if (ant_orient) row_n = (row_n + GRID_HEIGHT - 1) % GRID_HEIGHT;
          else row_n = (row_n + 1) % GRID_HEIGHT;
        end
        ant_col    = COL_W'(col_n);
        ant_row    = ROW_W'(row_n);
        ant_orient = ~ant_orient;
      end
      rep.col     = ant_col;
      rep.row     = ant_row;
      rep.heading = ant_heading;
      rep.orient  = ant_orient;
      expected_reports.push_back(rep);
    endfunction

    function void check_report(ant_report_t got);
      ant_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result shown with no request outstanding");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.col !== want.col) begin
        $error("ant_col: expected %0d, got %0d", want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("ant_row: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
      if (got.heading !== want.heading) begin
        $error("ant_heading: expected %0d, got %0d", want.heading, got.heading);
        errors++;
      end
      if (got.orient !== want.orient) begin
        $error("ant_orient: expected %0d, got %0d", want.orient, got.orient);
        errors++;
      end
      if (got.colour !== want.colour) begin
        $error("cell_colour: expected %0d, got %0d", want.colour, got.colour);
        errors++;
      end
      if (got.on_cell !== want.on_cell) begin
        $error("ant_on_cell: expected %0d, got %0d", want.on_cell, got.on_cell);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_cmd;
  logic [COL_W-1:0]  in_read_col;
  logic [ROW_W-1:0]  in_read_row;
  logic              cfg_we;
  logic [1:0]        cfg_addr;
  logic [CLR_W-1:0]  cfg_wdata;
  logic              out_valid;
  logic [COL_W-1:0]  out_ant_col;
  logic [ROW_W-1:0]  out_ant_row;
  logic [HEAD_W-1:0] out_ant_heading;
  logic              out_ant_orient;
  logic [CLR_W-1:0]  out_cell_colour;
  logic              out_ant_on_cell;

  ant_walk_scoreboard book;

  triangular_grid_ant_step_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_read_col     (in_read_col),
    .in_read_row     (in_read_row),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ant_col     (out_ant_col),
    .out_ant_row     (out_ant_row),
    .out_ant_heading (out_ant_heading),
    .out_ant_orient  (out_ant_orient),
    .out_cell_colour (out_cell_colour),
    .out_ant_on_cell (out_ant_on_cell)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver cannot hold results off, so every strobed cycle is a result to check.
  // Outputs are read right after the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      book.check_report('{col: out_ant_col, row: out_ant_row, heading: out_ant_heading,
                          orient: out_ant_orient, colour: out_cell_colour,
                          on_cell: out_ant_on_cell});
    end
  end

  // Drive one request and hold it until an edge finds busy low. That edge takes it, and
  // the scoreboard runs the request then. start is left high; the caller lowers it
  // only when a gap follows, so it never gets two updates in one time step.
  task automatic send_request(input logic cmd, input logic [COL_W-1:0] rc,
                              input logic [ROW_W-1:0] rr);
    start       <= 1'b1;
    in_cmd      <= cmd;
    in_read_col <= rc;
    in_read_row <= rr;
    do @(posedge clk); while (busy);
    book.note_request(cmd, rc, rr);
  endtask

  // Random sender gaps: each cycle the sender stays idle with the given odds.
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has been checked and the block
  // is idle. Spare cycles then follow so that a late or extra result would still show.
  task automatic drain();
    start <= 1'b0;
    while (book.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A register write is taken at the next edge. The enable then drops, and the task returns at the edge after that.
  task automatic write_rule(input logic [1:0] idx, input logic [CLR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    book.set_rule(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rules(input logic [CLR_W-1:0] r0, input logic [CLR_W-1:0] r1,
                           input logic [CLR_W-1:0] r2);
    write_rule(CFG_RULE0, r0);
    write_rule(CFG_RULE1, r1);
    write_rule(CFG_RULE2, r2);
  endtask

  // One random request. Most requests are steps, so the ant keeps walking into fresh
  // ground. Most reads land close to the ant, where cells have been painted. The rest
  // land anywhere on the grid.
  task automatic random_request(input int idle_pct);
    int pick;
    logic [COL_W-1:0] rc;
    logic [ROW_W-1:0] rr;
    sender_gap(idle_pct);
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_request(CMD_STEP, COL_W'($urandom), ROW_W'($urandom));
    end else if (pick < 82) begin
      rc = COL_W'(int'(book.ant_col) + int'($urandom_range(4)) - 2);
      rr = ROW_W'(int'(book.ant_row) + int'($urandom_range(4)) - 2);
      send_request(CMD_READ, rc, rr);
    end else begin
      send_request(CMD_READ, COL_W'($urandom), ROW_W'($urandom));
    end
  endtask

  initial begin
    logic [COL_W-1:0] prev_col;
    logic [ROW_W-1:0] prev_row;
    book        = new();
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_cmd      <= CMD_STEP;
    in_read_col <= '0;
    in_read_row <= '0;
    cfg_we      <= 1'b0;
    cfg_addr    <= CFG_RULE0;
    cfg_wdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    // The block clears its grid after reset with busy high. Wait that out.
    drain();

    // Directed part, under the reset turn rules first. Read the grid corners. Then read
    // the start cell, where the ant stands.
    send_request(CMD_READ, '0, '0);
    send_request(CMD_READ, '1, '1);
    send_request(CMD_READ, '1, '0);
    send_request(CMD_READ, '0, '1);
    send_request(CMD_READ, book.ant_col, book.ant_row);
    // Each step is followed by a read of the cell the ant just left, which must hold
    // the new colour.
    for (int i = 0; i < 5; i++) begin
      prev_col = book.ant_col;
      prev_row = book.ant_row;
      send_request(CMD_STEP, '1, '1);
      send_request(CMD_READ, prev_col, prev_row);
    end
    send_request(CMD_READ, book.ant_col, book.ant_row);
    drain();

    // A turn rule of 3 must act like 0. A write to the unused slot must change nothing.
    set_rules(2'd3, 2'd0, 2'd3);
    write_rule(CFG_UNUSED, 2'd1);
    for (int i = 0; i < 4; i++) send_request(CMD_STEP, '0, '0);
    send_request(CMD_READ, book.ant_col, book.ant_row);
    drain();

    // Random phases, one rule setting each. The gap odds change from phase to phase.
    // Each phase starts from a drained block, so the sender also pauses until every
    // result is in.
    for (int phase = 0; phase < 6; phase++) begin
      int idle_pct;
      case (phase)
        0: begin
          set_rules(2'd0, 2'd1, 2'd2);
          idle_pct = 0;
        end
        1: begin
          set_rules(2'd0, 2'd0, 2'd0);
          idle_pct = 58;
        end
        2: begin
          set_rules(2'd3, 2'd3, 2'd3);
          idle_pct = 0;
        end
        3: begin
          set_rules(2'd2, 2'd2, 2'd2);
          idle_pct = 6;
        end
        4: begin
          set_rules(2'd1, 2'd2, 2'd0);
          idle_pct = 58;
        end
        default: begin
          set_rules(CLR_W'($urandom), CLR_W'($urandom), CLR_W'($urandom));
          write_rule(CFG_UNUSED, CLR_W'($urandom));
          idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 180; n++) random_request(idle_pct);
      drain();
    end

    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Timeout. A correct run, counting the grid clear after reset, ends well within it.
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tgas_pkg.sv
rtl/tgas_ctrl.sv
rtl/tgas_dp.sv
rtl/triangular_grid_ant_step_top.sv
dv/testbench.sv
